### hdl/assert_macros.svh
// Assertion macros used by the checker file of the frame normalizer.
// Depends on nothing; files that assert take it in with an include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/mmfn_pkg.sv
// Shared constants and types of the min-max frame normalizer.
// Depends on nothing; used by every module of the block but mmfn_ram.
package mmfn_pkg;

   localparam int FRAME_DEPTH   = 64;
   localparam int SAMPLE_BITS   = 16;
   localparam int ADDR_BITS     = $clog2(FRAME_DEPTH);
   localparam int CNT_BITS      = $clog2(FRAME_DEPTH + 1);
   localparam int LEN_BITS      = 7;
   localparam int OUT_BITS      = 16;
   localparam int SCALE_SHIFT   = 17;
   localparam int NUM_BITS      = SAMPLE_BITS + SCALE_SHIFT + 1;
   localparam int STEP_BITS     = $clog2(SCALE_SHIFT);
   localparam int REQ_DATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = ((OUT_BITS + 7) / 8) * 8;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 3;

   localparam logic [LEN_BITS-1:0] LEN_RESET          = LEN_BITS'(64);
   localparam logic                CSR_IDX_OUT_LENGTH = 1'b0;
   localparam logic [OUT_BITS-1:0] OUT_MIN            = {1'b1, {(OUT_BITS-1){1'b0}}};
   localparam logic [OUT_BITS-1:0] OUT_MAX            = {1'b0, {(OUT_BITS-1){1'b1}}};

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic [SAMPLE_BITS-1:0]        span_type;

   typedef struct packed {
      span_type diff;
      span_type range;
      logic     pad;
      logic     last;
   } div_req_type;

   typedef struct packed {
      logic [OUT_BITS-1:0] value;
      logic                last;
   } div_res_type;

endpackage

### hdl/mmfn_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
module mmfn_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/mmfn_div.sv
// Bit-serial restoring divider that turns one stored sample into a Q1.15 value.
// Depends on mmfn_pkg.
module mmfn_div (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  mmfn_pkg::div_req_type req,
   input  logic                 res_ack,
   output logic                 res_valid,
   output mmfn_pkg::div_res_type res
);
   import mmfn_pkg::*;

   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [SAMPLE_BITS:0]      rem_ff, rem_in;
   logic [SAMPLE_BITS:0]      den_ff, den_in;
   logic [SCALE_SHIFT-1:0]    low_ff, low_in;
   logic [SCALE_SHIFT-1:0]    quot_ff, quot_in;
   logic [STEP_BITS-1:0]      step_ff, step_in;
   logic                      pad_ff, pad_in;
   logic                      zero_ff, zero_in;
   logic                      last_ff, last_in;
   logic [NUM_BITS-1:0]       num;
   logic [SAMPLE_BITS+1:0]    trial;
   logic [SAMPLE_BITS+1:0]    diff_den;
   logic                      fits;

   // The dividend is diff * 2^17 + range and the divisor 2 * range; the
   // quotient never exceeds 2^16, so 17 quotient bits are produced.
   always_comb begin
      num      = NUM_BITS'({req.diff, {SCALE_SHIFT{1'b0}}}) + NUM_BITS'(req.range);
      trial    = {rem_ff, low_ff[SCALE_SHIFT-1]};
      diff_den = trial - {1'b0, den_ff};
      fits     = trial >= {1'b0, den_ff};

      busy_in = busy_ff;
      done_in = done_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      low_in  = low_ff;
      quot_in = quot_ff;
      step_in = step_ff;
      pad_in  = pad_ff;
      zero_in = zero_ff;
      last_in = last_ff;

      if (start) begin
         rem_in  = num[NUM_BITS-1:SCALE_SHIFT];
         low_in  = num[SCALE_SHIFT-1:0];
         den_in  = {req.range, 1'b0};
         quot_in = '0;
         step_in = STEP_BITS'(SCALE_SHIFT - 1);
         pad_in  = req.pad;
         zero_in = (req.range == '0);
         last_in = req.last;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         rem_in  = fits ? diff_den[SAMPLE_BITS:0] : trial[SAMPLE_BITS:0];
         quot_in = {quot_ff[SCALE_SHIFT-2:0], fits};
         low_in  = {low_ff[SCALE_SHIFT-2:0], 1'b0};
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end else if (done_ff && res_ack) begin
         done_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      low_ff  <= low_in;
      quot_ff <= quot_in;
      step_ff <= step_in;
      pad_ff  <= pad_in;
      zero_ff <= zero_in;
      last_ff <= last_in;
   end

   // Subtracting 2^15 from the quotient flips its top bit; a quotient of 2^16
   // is an exact +1 and saturates.
   always_comb begin
      if (pad_ff) begin
         res.value = '0;
      end else if (zero_ff) begin
         res.value = OUT_MIN;
      end else if (quot_ff[OUT_BITS]) begin
         res.value = OUT_MAX;
      end else begin
         res.value = {~quot_ff[OUT_BITS-1], quot_ff[OUT_BITS-2:0]};
      end
      res.last = last_ff;
   end

   assign res_valid = done_ff;

endmodule

### hdl/minmax_frame_normalizer.sv
// Top level of the min-max frame normalizer: frame loading, result sequencing,
// register port and output register. Depends on mmfn_pkg, mmfn_ram and mmfn_div.
//
// Usage. Samples of a frame arrive as words on the req_ stream, one sample per
// word, with req_tlast set on the last sample of the frame. While a frame
// loads the block takes one word per cycle, stores the first 64 samples in a
// sample RAM and tracks the running minimum and maximum, which both restart
// from the first sample of each frame. The word with req_tlast starts the
// result burst: out_length words on the rsp_ stream (clamped to 1..64), each
// a stored sample mapped to -1..+1 in Q1.15, zero for positions past the
// frame length, with rsp_tlast on the final word. During the burst req_tready
// is low. Each result takes one RAM read, a setup state, the bit-serial
// divider (one quotient bit per cycle) and a hand-off into the output
// register; the next result starts only after the last is handed off.
// The output register holds a word until rsp_tready takes it; a stalled
// receiver pauses the sequencer but loses nothing, and the next frame may
// load while the final word still waits. Reset clears the sequencer, the
// sample counter, the trackers and the output valid flag, sets out_length to
// 64 and leaves the sample RAM as it is: results for entries not written in
// the current frame are forced to zero. The user writes out_length at byte
// address 0 over the csr_ port only while idle; the block does not enforce it.
module minmax_frame_normalizer (
   input  logic                                  clock,
   input  logic                                  reset,
   // Input stream: tdata = sample; tlast = frame_end.
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [mmfn_pkg::REQ_DATA_BITS-1:0]    req_tdata,
   input  logic                                  req_tlast,
   // Result stream: tdata = norm_value; tlast = out_last.
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [mmfn_pkg::RSP_DATA_BITS-1:0]    rsp_tdata,
   output logic                                  rsp_tlast,
   // Register port.
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [mmfn_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  logic [mmfn_pkg::CSR_DATA_BITS-1:0]    csr_pwdata,
   output logic [mmfn_pkg::CSR_DATA_BITS-1:0]    csr_prdata,
   output logic                                  csr_pready
);
   import mmfn_pkg::*;

   localparam logic [1:0] ST_LOAD  = 2'd0;
   localparam logic [1:0] ST_READ  = 2'd1;
   localparam logic [1:0] ST_START = 2'd2;
   localparam logic [1:0] ST_WAIT  = 2'd3;

   logic [1:0]                state_ff, state_in;
   logic [LEN_BITS-1:0]       out_length_ff, out_length_in;
   logic [CNT_BITS-1:0]       seen_ff, seen_in;
   logic [CNT_BITS-1:0]       flen_ff, flen_in;
   logic [CNT_BITS-1:0]       len_ff, len_in;
   logic [ADDR_BITS-1:0]      idx_ff, idx_in;
   sample_type                min_ff, min_in;
   sample_type                max_ff, max_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [OUT_BITS-1:0]       rsp_data_ff, rsp_data_in;
   logic                      rsp_last_ff, rsp_last_in;

   sample_type                sample;
   logic                      req_fire;
   logic                      csr_wr;
   logic                      store_wr;
   logic [SAMPLE_BITS-1:0]    ram_rdata;
   logic                      div_start;
   div_req_type               div_req;
   logic                      div_valid;
   div_res_type               div_res;
   logic                      div_ack;
   logic [CNT_BITS-1:0]       idx_wide;

   assign sample     = sample_type'(req_tdata[SAMPLE_BITS-1:0]);
   assign req_tready = (state_ff == ST_LOAD);
   assign req_fire   = req_tvalid && req_tready;
   assign store_wr   = req_fire && (seen_ff < CNT_BITS'(FRAME_DEPTH));
   assign idx_wide   = CNT_BITS'(idx_ff);

   // Register port: one register, no wait states.
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      out_length_in = out_length_ff;
      if (csr_wr && (csr_paddr[2] == CSR_IDX_OUT_LENGTH)) begin
         out_length_in = csr_pwdata[LEN_BITS-1:0];
      end
      if (csr_paddr[2] == CSR_IDX_OUT_LENGTH) begin
         csr_prdata = CSR_DATA_BITS'(out_length_ff);
      end else begin
         csr_prdata = '0;
      end
   end

   mmfn_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (FRAME_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (store_wr),
      .wr_addr (seen_ff[ADDR_BITS-1:0]),
      .wr_data (req_tdata[SAMPLE_BITS-1:0]),
      .rd_addr (idx_ff),
      .rd_data (ram_rdata)
   );

   // The divider works on the offset from the minimum and the frame's span,
   // both of which fit the sample width as unsigned values.
   assign div_start     = (state_ff == ST_START);
   assign div_req.diff  = ram_rdata - span_type'(min_ff);
   assign div_req.range = span_type'(max_ff) - span_type'(min_ff);
   assign div_req.pad   = (idx_wide >= flen_ff);
   assign div_req.last  = ((idx_wide + 1'b1) == len_ff);

   mmfn_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .req       (div_req),
      .res_ack   (div_ack),
      .res_valid (div_valid),
      .res       (div_res)
   );

   assign div_ack = (state_ff == ST_WAIT) && div_valid && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in     = state_ff;
      seen_in      = seen_ff;
      flen_in      = flen_ff;
      len_in       = len_ff;
      idx_in       = idx_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         ST_LOAD: begin
            if (req_fire) begin
               // The first sample of a frame seeds both trackers.
               if (seen_ff == '0) begin
                  min_in = sample;
                  max_in = sample;
               end else begin
                  if (sample < min_ff) min_in = sample;
                  if (sample > max_ff) max_in = sample;
               end
               if (store_wr) begin
                  seen_in = seen_ff + 1'b1;
               end
               if (req_tlast) begin
                  flen_in = store_wr ? seen_ff + 1'b1 : seen_ff;
                  seen_in = '0;
                  idx_in  = '0;
                  if (out_length_ff == '0) begin
                     len_in = CNT_BITS'(1);
                  end else if (out_length_ff > LEN_BITS'(FRAME_DEPTH)) begin
                     len_in = CNT_BITS'(FRAME_DEPTH);
                  end else begin
                     len_in = CNT_BITS'(out_length_ff);
                  end
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            state_in = ST_START;
         end
         ST_START: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (div_ack) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = div_res.value;
               rsp_last_in  = div_res.last;
               if (div_res.last) begin
                  state_in = ST_LOAD;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         out_length_ff <= LEN_RESET;
         seen_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         min_ff        <= '0;
         max_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         out_length_ff <= out_length_in;
         seen_ff       <= seen_in;
         rsp_valid_ff  <= rsp_valid_in;
         min_ff        <= min_in;
         max_ff        <= max_in;
      end
      flen_ff     <= flen_in;
      len_ff      <= len_in;
      idx_ff      <= idx_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_BITS'(rsp_data_ff);
   assign rsp_tlast  = rsp_last_ff;

endmodule

### hdl/mmfn_checker.sv
// Port-level checker of the min-max frame normalizer, bound to the top level.
// Depends on mmfn_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mmfn_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_tvalid,
   input logic                                  req_tready,
   input logic                                  req_tlast,
   input logic                                  rsp_tvalid,
   input logic                                  rsp_tready,
   input logic [mmfn_pkg::RSP_DATA_BITS-1:0]    rsp_tdata,
   input logic                                  rsp_tlast,
   input logic [mmfn_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input logic [mmfn_pkg::CSR_DATA_BITS-1:0]    csr_prdata
);
   import mmfn_pkg::*;

   // A stalled result word holds its value and its last flag.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "result word changed under stall")

   // The last sample of a frame closes the input.
   `ASSERT_NEXT(a_frame_close, clock, reset, req_tvalid && req_tready && req_tlast,
      !req_tready, "input still open after frame end")

   // While a result word other than the final one is valid, no sample is taken.
   `ASSERT_IMPLIES(a_burst_busy, clock, reset, rsp_tvalid && !rsp_tlast,
      !req_tready, "input open during a result burst")

   // The length register reads back within its seven bits.
   `ASSERT_IMPLIES(a_csr_read, clock, reset, csr_paddr[2] == CSR_IDX_OUT_LENGTH,
      csr_prdata[CSR_DATA_BITS-1:LEN_BITS] == '0, "length register reads wide")

endmodule

bind minmax_frame_normalizer mmfn_checker u_mmfn_checker (.*);
